### rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

    // Field widths of the item ports
    localparam int OPCODE_W = 2;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int CELL_W   = 16;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    // Character codes and cell constants
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
    localparam logic [CELL_W-1:0] CHAR_MASK  = 16'h00FF;
    localparam logic [CELL_W-1:0] ATTR_RESET = 16'h1200;

    // Commands from the sequencer to the sweep counter
    typedef struct packed {
        logic load;
        logic step;
    } sweep_ctl_t;

    // Cell value: attribute ORed with the masked character
    function automatic logic [CELL_W-1:0] make_cell(input logic [CELL_W-1:0] attr,
                                                    input logic [CHAR_W-1:0] ch);
        make_cell = attr | ({{(CELL_W-CHAR_W){1'b0}}, ch} & CHAR_MASK);
    endfunction

endpackage

### rtl/core/tcw_cell_ram.sv
// Cell store: one write port, one read port with registered read data.
module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0] wr_data,
    input  logic [AW-1:0]              rd_addr,
    output logic [tcw_pkg::CELL_W-1:0] rd_data
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/tcw_sweep.sv
// Shared address sweep counter used by the clear, scroll and reset passes.
module tcw_sweep #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcw_pkg::sweep_ctl_t ctl,
    input  logic [AW-1:0]       start_addr,
    input  logic [AW-1:0]       end_addr,
    output logic [AW-1:0]       cnt,
    output logic                last
);

    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;
    logic [AW-1:0] end_reg;
    logic [AW-1:0] end_next;

    // Load a new range or advance one address
    always_comb
    begin
        cnt_next = cnt_reg;
        end_next = end_reg;
        if (ctl.load)
        begin
            cnt_next = start_addr;
            end_next = end_addr;
        end
        else if (ctl.step)
        begin
            cnt_next = cnt_reg + AW'(1);
        end
    end

    // Out of reset the counter covers the whole store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            end_reg <= AW'(DEPTH - 1);
        end
        else
        begin
            cnt_reg <= cnt_next;
            end_reg <= end_next;
        end
    end

    assign cnt  = cnt_reg;
    assign last = (cnt_reg == end_reg);

endmodule

### rtl/core/text_console_writer.sv
// Top level of the text console writer: sequencer, cursor and result register.
//
// Text-mode console over a store of ROWS x COLUMNS 16-bit cells. A put writes
// (cell_attribute | char) at the cursor and advances it; LF or CR, or running
// past the last column, moves to column 0 of the next row, and moving past the
// last row scrolls the screen up one line and fills the bottom line with
// spaces. A clear fills every cell with spaces and homes the cursor; a read
// returns one cell (zero when the index is past the store). Every item gives
// one result. All store traffic goes through one write port and one read port
// under a single sweep counter: a put takes a write step and a finish step
// (with a newline step when it runs off the line end), a read an address step
// and a data step (no data step when the index is past the store), a scroll a
// read and a write step per cell of the upper rows and then a fill of the
// bottom row, and a clear one write per cell. in_ready comes back with the
// result; a result still waiting in the output register holds the sequencer
// in its last step. After reset the store is swept to zero, one cell per
// cycle, and no item is taken until that pass ends.
// The block takes one item at a time; the result register lets a new item be
// taken while the previous result still waits. cell_attribute must be written
// through the cfg port only while the block is idle; the block itself does not
// enforce this.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tcw_pkg::CELL_W-1:0]   cfg_data,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tcw_pkg::OPCODE_W-1:0] opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]  cell_index,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tcw_pkg::CHAR_W-1:0]   char_echo,
    output logic [tcw_pkg::COL_W-1:0]    cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]    cursor_row,
    output logic [tcw_pkg::CELL_W-1:0]   cell_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int XW         = $clog2(COLUMNS);
    localparam int YW         = $clog2(ROWS);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT,
        ST_NEWLINE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_FILL,
        ST_CLEAR,
        ST_READ,
        ST_RDATA,
        ST_FINISH
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [XW-1:0]                x_reg;
    logic [XW-1:0]                x_next;
    logic [YW-1:0]                y_reg;
    logic [YW-1:0]                y_next;
    logic [AW-1:0]                row_base_reg;
    logic [AW-1:0]                row_base_next;
    logic [tcw_pkg::CELL_W-1:0]   attr_reg;
    logic [tcw_pkg::CELL_W-1:0]   attr_next;
    logic [tcw_pkg::CHAR_W-1:0]   ch_reg;
    logic [tcw_pkg::CHAR_W-1:0]   ch_next;
    logic [tcw_pkg::INDEX_W-1:0]  idx_reg;
    logic [tcw_pkg::INDEX_W-1:0]  idx_next;
    logic [tcw_pkg::CHAR_W-1:0]   echo_reg;
    logic [tcw_pkg::CHAR_W-1:0]   echo_next;
    logic [tcw_pkg::CELL_W-1:0]   data_reg;
    logic [tcw_pkg::CELL_W-1:0]   data_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [tcw_pkg::CHAR_W-1:0]   out_echo_reg;
    logic [tcw_pkg::CHAR_W-1:0]   out_echo_next;
    logic [tcw_pkg::COL_W-1:0]    out_col_reg;
    logic [tcw_pkg::COL_W-1:0]    out_col_next;
    logic [tcw_pkg::ROW_W-1:0]    out_row_reg;
    logic [tcw_pkg::ROW_W-1:0]    out_row_next;
    logic [tcw_pkg::CELL_W-1:0]   out_data_reg;
    logic [tcw_pkg::CELL_W-1:0]   out_data_next;

    tcw_pkg::sweep_ctl_t          sweep_ctl;
    logic [AW-1:0]                sweep_start;
    logic [AW-1:0]                sweep_end;
    logic [AW-1:0]                sweep_cnt;
    logic                         sweep_last;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [tcw_pkg::CELL_W-1:0]   wr_data;
    logic [AW-1:0]                rd_addr;
    logic [tcw_pkg::CELL_W-1:0]   rd_data;

    logic                         in_xfer;
    logic                         out_free;
    logic                         x_at_end;
    logic                         y_at_end;
    logic                         idx_in_range;
    logic [AW-1:0]                cursor_addr;
    logic [tcw_pkg::CELL_W-1:0]   space_cell;

    tcw_sweep #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_sweep (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sweep_ctl),
        .start_addr (sweep_start),
        .end_addr   (sweep_end),
        .cnt        (sweep_cnt),
        .last       (sweep_last)
    );

    tcw_cell_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Handshake and helper terms
    assign in_ready     = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign in_xfer      = in_valid && in_ready;
    assign out_free     = !out_valid_reg || out_ready;
    assign x_at_end     = (x_reg == XW'(COLUMNS - 1));
    assign y_at_end     = (y_reg == YW'(ROWS - 1));
    assign idx_in_range = (32'(idx_reg) < 32'(CELL_COUNT));
    assign cursor_addr  = row_base_reg + AW'(x_reg);
    assign space_cell   = tcw_pkg::make_cell(attr_reg, tcw_pkg::SPACE_CODE);

    // Read address: scroll source row, else the requested cell
    always_comb
    begin
        if (state_reg == ST_COPY_RD)
        begin
            rd_addr = AW'(sweep_cnt + AW'(COLUMNS));
        end
        else
        begin
            rd_addr = AW'(idx_reg);
        end
    end

    // Write port control
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sweep_cnt;
        wr_data = space_cell;
        case (state_reg)
            ST_INIT:
            begin
                wr_en   = 1'b1;
                wr_data = '0;
            end
            ST_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = cursor_addr;
                wr_data = tcw_pkg::make_cell(attr_reg, ch_reg);
            end
            ST_COPY_WR:
            begin
                wr_en   = 1'b1;
                wr_data = rd_data;
            end
            ST_FILL, ST_CLEAR:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        row_base_next  = row_base_reg;
        attr_next      = attr_reg;
        ch_next        = ch_reg;
        idx_next       = idx_reg;
        echo_next      = echo_reg;
        data_next      = data_reg;
        out_valid_next = out_valid_reg;
        out_echo_next  = out_echo_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_data_next  = out_data_reg;
        sweep_ctl      = '0;
        sweep_start    = '0;
        sweep_end      = AW'(CELL_COUNT - 1);

        if (cfg_valid && cfg_ready)
        begin
            attr_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // Zero the store after reset
            ST_INIT:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_ctl.step = 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    ch_next   = char_code;
                    idx_next  = cell_index;
                    echo_next = '0;
                    data_next = '0;
                    case (opcode)
                        tcw_pkg::OP_PUT:
                        begin
                            echo_next = char_code;
                            if (char_code == tcw_pkg::CHAR_LF ||
                                char_code == tcw_pkg::CHAR_CR)
                            begin
                                state_next = ST_NEWLINE;
                            end
                            else
                            begin
                                state_next = ST_PUT;
                            end
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            sweep_ctl.load = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        tcw_pkg::OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            // Character write, then advance the cursor
            ST_PUT:
            begin
                if (x_at_end)
                begin
                    state_next = ST_NEWLINE;
                end
                else
                begin
                    x_next     = x_reg + XW'(1);
                    state_next = ST_FINISH;
                end
            end

            ST_NEWLINE:
            begin
                x_next = '0;
                if (y_at_end)
                begin
                    sweep_ctl.load = 1'b1;
                    sweep_end      = AW'(CELL_COUNT - COLUMNS - 1);
                    state_next     = ST_COPY_RD;
                end
                else
                begin
                    y_next        = y_reg + YW'(1);
                    row_base_next = AW'(row_base_reg + AW'(COLUMNS));
                    state_next    = ST_FINISH;
                end
            end

            // Scroll: move each cell up one row
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end

            ST_COPY_WR:
            begin
                if (sweep_last)
                begin
                    sweep_ctl.load = 1'b1;
                    sweep_start    = AW'(CELL_COUNT - COLUMNS);
                    state_next     = ST_FILL;
                end
                else
                begin
                    sweep_ctl.step = 1'b1;
                    state_next     = ST_COPY_RD;
                end
            end

            // Scroll: blank the bottom row
            ST_FILL:
            begin
                if (sweep_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    sweep_ctl.step = 1'b1;
                end
            end

            ST_CLEAR:
            begin
                if (sweep_last)
                begin
                    x_next        = '0;
                    y_next        = '0;
                    row_base_next = '0;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    sweep_ctl.step = 1'b1;
                end
            end

            // Cell read: address goes out now, data lands next cycle
            ST_READ:
            begin
                if (idx_in_range)
                begin
                    state_next = ST_RDATA;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_RDATA:
            begin
                data_next  = rd_data;
                state_next = ST_FINISH;
            end

            // Hand the result to the output register once it is free
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_echo_next  = echo_reg;
                    out_col_next   = tcw_pkg::COL_W'(x_reg);
                    out_row_next   = tcw_pkg::ROW_W'(y_reg);
                    out_data_next  = data_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, item payload and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            x_reg         <= '0;
            y_reg         <= '0;
            row_base_reg  <= '0;
            attr_reg      <= tcw_pkg::ATTR_RESET;
            out_valid_reg <= 1'b0;
            ch_reg        <= '0;
            idx_reg       <= '0;
            echo_reg      <= '0;
            data_reg      <= '0;
            out_echo_reg  <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            row_base_reg  <= row_base_next;
            attr_reg      <= attr_next;
            out_valid_reg <= out_valid_next;
            ch_reg        <= ch_next;
            idx_reg       <= idx_next;
            echo_reg      <= echo_next;
            data_reg      <= data_next;
            out_echo_reg  <= out_echo_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign char_echo  = out_echo_reg;
    assign cursor_col = out_col_reg;
    assign cursor_row = out_row_reg;
    assign cell_data  = out_data_reg;

    // Cursor never leaves the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(x_reg) < 32'(COLUMNS)) && (32'(y_reg) < 32'(ROWS)))
        else $error("cursor outside screen");

    // Taking an item makes the block busy on the next cycle
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("block ready right after an input transfer");

    // Bottom-row fill only happens with the cursor on the last row
    a_fill_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> y_at_end && (x_reg == '0))
        else $error("scroll fill with cursor off the last row");

    // End of a clear pass homes the cursor
    a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) && sweep_last |=>
            (x_reg == '0) && (y_reg == '0) && (row_base_reg == '0))
        else $error("clear did not home the cursor");

endmodule

### verif/tb_top.sv
// Self-checking testbench for text_console_writer: directed table and random items.
module tb_top;

    localparam int COLUMNS        = 80;
    localparam int ROWS           = 25;
    localparam int CELLS          = COLUMNS * ROWS;
    localparam int INDEX_MAX      = (1 << tcw_pkg::INDEX_W) - 1;
    localparam int PHASE_ITEMS    = 400;
    localparam int PHASE_COUNT    = 5;
    localparam int DRAIN_CYCLES   = 64;
    localparam int TIMEOUT_UNITS  = 200_000_000;

    // Opcode that the block leaves without effect
    localparam logic [tcw_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [tcw_pkg::CHAR_W-1:0] echo;
        logic [tcw_pkg::COL_W-1:0]  col;
        logic [tcw_pkg::ROW_W-1:0]  row;
        logic [tcw_pkg::CELL_W-1:0] data;
    } console_result_t;

    typedef struct packed {
        logic [tcw_pkg::OPCODE_W-1:0] op;
        logic [tcw_pkg::CHAR_W-1:0]   ch;
        logic [tcw_pkg::INDEX_W-1:0]  idx;
        logic [7:0]                   reps;
        logic                         typed;
        console_result_t              want;
    } script_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [tcw_pkg::CELL_W-1:0]   cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    logic [tcw_pkg::OPCODE_W-1:0] opcode;
    logic [tcw_pkg::CHAR_W-1:0]   char_code;
    logic [tcw_pkg::INDEX_W-1:0]  cell_index;
    logic                         out_valid;
    logic                         out_ready;
    logic [tcw_pkg::CHAR_W-1:0]   char_echo;
    logic [tcw_pkg::COL_W-1:0]    cursor_col;
    logic [tcw_pkg::ROW_W-1:0]    cursor_row;
    logic [tcw_pkg::CELL_W-1:0]   cell_data;

    // Model state: screen contents, cursor and attribute
    logic [tcw_pkg::CELL_W-1:0] screen [CELLS];
    logic [tcw_pkg::COL_W-1:0]  col_pos;
    logic [tcw_pkg::ROW_W-1:0]  row_pos;
    logic [tcw_pkg::CELL_W-1:0] attr_now;

    console_result_t pending_results [$];
    script_row_t     script_rows [$];

    int send_gap_pct;
    int stall_pct;
    int error_count;
    int puts_done;
    int reads_done;
    int clears_done;
    int scrolls_done;
    int wraps_done;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .char_echo  (char_echo),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .cell_data  (cell_data)
    );

    always #6 clk = ~clk;

    // Move to column 0 of the next row; scroll when already on the last row
    function automatic void line_feed();
        int i;
        if (row_pos == ROWS - 1)
        begin
            for (i = 0; i < CELLS - COLUMNS; i++)
                screen[i] = screen[i + COLUMNS];
            for (i = CELLS - COLUMNS; i < CELLS; i++)
                screen[i] = attr_now | {8'h00, tcw_pkg::SPACE_CODE};
            scrolls_done++;
        end
        else
        begin
            row_pos = row_pos + 1'b1;
        end
        col_pos = '0;
    endfunction

    // Apply one item to the model and return the result it should produce
    function automatic console_result_t console_step(
        input logic [tcw_pkg::OPCODE_W-1:0] op,
        input logic [tcw_pkg::CHAR_W-1:0]   ch,
        input logic [tcw_pkg::INDEX_W-1:0]  idx);
        console_result_t r;
        int i;
        r = '0;
        case (op)
            tcw_pkg::OP_PUT:
            begin
                r.echo = ch;
                puts_done++;
                if (ch == tcw_pkg::CHAR_LF || ch == tcw_pkg::CHAR_CR)
                begin
                    line_feed();
                end
                else
                begin
                    screen[int'(row_pos) * COLUMNS + int'(col_pos)] = attr_now | {8'h00, ch};
                    if (col_pos == COLUMNS - 1)
                    begin
                        wraps_done++;
                        line_feed();
                    end
                    else
                    begin
                        col_pos = col_pos + 1'b1;
                    end
                end
            end
            tcw_pkg::OP_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    screen[i] = attr_now | {8'h00, tcw_pkg::SPACE_CODE};
                col_pos = '0;
                row_pos = '0;
                clears_done++;
            end
            tcw_pkg::OP_READ:
            begin
                reads_done++;
                if (idx < CELLS)
                    r.data = screen[idx];
            end
            default: ;
        endcase
        r.col = col_pos;
        r.row = row_pos;
        return r;
    endfunction

    // Drive one item at the falling edge, hold until the transfer, record the expectation
    task automatic send_item(input logic [tcw_pkg::OPCODE_W-1:0] op,
                             input logic [tcw_pkg::CHAR_W-1:0]   ch,
                             input logic [tcw_pkg::INDEX_W-1:0]  idx,
                             input logic                         use_typed,
                             input console_result_t              typed_want);
        console_result_t predicted;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        opcode     = op;
        char_code  = ch;
        cell_index = idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = console_step(op, ch, idx);
        pending_results.push_back(use_typed ? typed_want : predicted);
        @(negedge clk);
    endtask

    task automatic write_attribute(input logic [tcw_pkg::CELL_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        attr_now = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic add_row(input logic [tcw_pkg::OPCODE_W-1:0] op,
                           input logic [tcw_pkg::CHAR_W-1:0] ch,
                           input logic [tcw_pkg::INDEX_W-1:0] idx, input int reps,
                           input logic typed, input logic [tcw_pkg::CHAR_W-1:0] echo,
                           input int col, input int row,
                           input logic [tcw_pkg::CELL_W-1:0] data);
        script_row_t s;
        s.op   = op;
        s.ch   = ch;
        s.idx  = idx;
        s.reps = 8'(reps);
        s.typed = typed;
        s.want = '{echo: echo, col: tcw_pkg::COL_W'(col), row: tcw_pkg::ROW_W'(row),
                   data: data};
        script_rows.push_back(s);
    endtask

    // Mostly printable text, some newlines, some arbitrary bytes
    function automatic logic [tcw_pkg::CHAR_W-1:0] text_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return ($urandom_range(0, 1) != 0) ? tcw_pkg::CHAR_LF : tcw_pkg::CHAR_CR;
        if (pick < 13)
            return tcw_pkg::CHAR_W'($urandom_range(0, 255));
        return tcw_pkg::CHAR_W'($urandom_range(32, 126));
    endfunction

    // Reads favor the rows near the cursor, where text was just written
    function automatic logic [tcw_pkg::INDEX_W-1:0] read_address();
        int pick;
        int line;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return tcw_pkg::INDEX_W'($urandom_range(CELLS, INDEX_MAX));
        if (pick < 30)
            return tcw_pkg::INDEX_W'($urandom_range(0, CELLS - 1));
        line = (row_pos > 0 && $urandom_range(0, 1) != 0) ? int'(row_pos) - 1 : int'(row_pos);
        return tcw_pkg::INDEX_W'(line * COLUMNS + $urandom_range(0, COLUMNS - 1));
    endfunction

    // One burst of related items; reports how many were not no-ops
    task automatic random_burst(output int n_counted);
        int kind;
        int len;
        int k;
        logic [tcw_pkg::OPCODE_W-1:0] op;
        n_counted = 0;
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            // text run, sometimes long enough to wrap a line
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
            for (k = 0; k < len; k++)
                send_item(tcw_pkg::OP_PUT, text_char(), tcw_pkg::INDEX_W'($urandom),
                          1'b0, '0);
            n_counted = len;
        end
        else if (kind < 75)
        begin
            len = $urandom_range(1, 6);
            for (k = 0; k < len; k++)
                send_item(tcw_pkg::OP_READ, tcw_pkg::CHAR_W'($urandom), read_address(),
                          1'b0, '0);
            n_counted = len;
        end
        else if (kind < 83)
        begin
            len = $urandom_range(1, 8);
            for (k = 0; k < len; k++)
                send_item(tcw_pkg::OP_PUT,
                          ($urandom_range(0, 1) != 0) ? tcw_pkg::CHAR_LF : tcw_pkg::CHAR_CR,
                          tcw_pkg::INDEX_W'($urandom), 1'b0, '0);
            n_counted = len;
        end
        else if (kind < 87)
        begin
            len = $urandom_range(1, 3);
            for (k = 0; k < len; k++)
                send_item(OP_UNUSED, tcw_pkg::CHAR_W'($urandom),
                          tcw_pkg::INDEX_W'($urandom), 1'b0, '0);
        end
        else if (kind < 89)
        begin
            send_item(tcw_pkg::OP_CLEAR, tcw_pkg::CHAR_W'($urandom),
                      tcw_pkg::INDEX_W'($urandom), 1'b0, '0);
            n_counted = 1;
        end
        else
        begin
            // unstructured mix with fully random fields
            len = $urandom_range(1, 5);
            for (k = 0; k < len; k++)
            begin
                case ($urandom_range(0, 2))
                    0:       op = tcw_pkg::OP_PUT;
                    1:       op = tcw_pkg::OP_READ;
                    default: op = OP_UNUSED;
                endcase
                send_item(op, tcw_pkg::CHAR_W'($urandom), tcw_pkg::INDEX_W'($urandom),
                          1'b0, '0);
                if (op != OP_UNUSED)
                    n_counted++;
            end
        end
    endtask

    task automatic check_result(input console_result_t got);
        console_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("result with nothing outstanding: echo %0h col %0d row %0d data %0h",
                   got.echo, got.col, got.row, got.data);
            error_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.echo !== want.echo)
            begin
                $error("char_echo: expected %0h, got %0h", want.echo, got.echo);
                error_count++;
            end
            if (got.col !== want.col)
            begin
                $error("cursor_col: expected %0d, got %0d", want.col, got.col);
                error_count++;
            end
            if (got.row !== want.row)
            begin
                $error("cursor_row: expected %0d, got %0d", want.row, got.row);
                error_count++;
            end
            if (got.data !== want.data)
            begin
                $error("cell_data: expected %0h, got %0h", want.data, got.data);
                error_count++;
            end
        end
    endtask

    // Result side: ready changes at the falling edge
    always @(negedge clk)
        out_ready = ($urandom_range(0, 99) >= stall_pct);

    // Result side: transfers sampled at the rising edge
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            check_result({char_echo, cursor_col, cursor_row, cell_data});

    // Stimulus
    initial
    begin
        int i;
        int k;
        int phase;
        int counted;
        int burst_count;
        script_row_t s;

        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        opcode     = tcw_pkg::OP_PUT;
        char_code  = '0;
        cell_index = '0;
        out_ready  = 1'b0;
        send_gap_pct = 0;
        stall_pct    = 0;
        error_count  = 0;
        for (i = 0; i < CELLS; i++)
            screen[i] = '0;
        col_pos  = '0;
        row_pos  = '0;
        attr_now = tcw_pkg::ATTR_RESET;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: reset state, field extremes, newline codes, line end, scrolls, clear
        add_row(tcw_pkg::OP_READ,  8'h00, 11'd0,    1, 1'b1, 8'h00, 0, 0,  16'h0000);
        add_row(tcw_pkg::OP_READ,  8'h00, 11'd1999, 1, 1'b1, 8'h00, 0, 0,  16'h0000);
        add_row(tcw_pkg::OP_READ,  8'hFF, 11'd2047, 1, 1'b1, 8'h00, 0, 0,  16'h0000);
        add_row(tcw_pkg::OP_PUT,   8'h41, 11'd0,    1, 1'b1, 8'h41, 1, 0,  16'h0000);
        add_row(tcw_pkg::OP_READ,  8'h00, 11'd0,    1, 1'b1, 8'h00, 1, 0,  16'h1241);
        add_row(OP_UNUSED,         8'hFF, 11'd2047, 1, 1'b1, 8'h00, 1, 0,  16'h0000);
        add_row(tcw_pkg::OP_PUT,   8'hFF, 11'd2047, 1, 1'b1, 8'hFF, 2, 0,  16'h0000);
        add_row(tcw_pkg::OP_PUT,   8'h00, 11'd0,    1, 1'b1, 8'h00, 3, 0,  16'h0000);
        add_row(tcw_pkg::OP_READ,  8'h00, 11'd1,    1, 1'b1, 8'h00, 3, 0,  16'h12FF);
        add_row(tcw_pkg::OP_READ,  8'h00, 11'd2,    1, 1'b1, 8'h00, 3, 0,  16'h1200);
        add_row(tcw_pkg::OP_PUT, tcw_pkg::CHAR_LF, 11'd0, 1, 1'b1, 8'h0A, 0, 1, 16'h0000);
        add_row(tcw_pkg::OP_PUT, tcw_pkg::CHAR_CR, 11'd0, 1, 1'b1, 8'h0D, 0, 2, 16'h0000);
        add_row(tcw_pkg::OP_PUT,   8'h42, 11'd0,   79, 1'b0, 8'h00, 0, 0,  16'h0000);
        // last column reached: wraps like a newline
        add_row(tcw_pkg::OP_PUT,   8'h43, 11'd0,    1, 1'b1, 8'h43, 0, 3,  16'h0000);
        add_row(tcw_pkg::OP_READ,  8'h00, 11'd239,  1, 1'b1, 8'h00, 0, 3,  16'h1243);
        add_row(tcw_pkg::OP_PUT, tcw_pkg::CHAR_LF, 11'd0, 21, 1'b0, 8'h00, 0, 0, 16'h0000);
        // newline on the last row scrolls, cursor stays on it
        add_row(tcw_pkg::OP_PUT, tcw_pkg::CHAR_LF, 11'd0, 1, 1'b1, 8'h0A, 0, 24, 16'h0000);
        add_row(tcw_pkg::OP_READ,  8'h00, 11'd1920, 1, 1'b1, 8'h00, 0, 24, 16'h1220);
        add_row(tcw_pkg::OP_READ,  8'h00, 11'd159,  1, 1'b1, 8'h00, 0, 24, 16'h1243);
        add_row(tcw_pkg::OP_PUT,   8'h44, 11'd0,   79, 1'b0, 8'h00, 0, 0,  16'h0000);
        // wrap on the last row scrolls too
        add_row(tcw_pkg::OP_PUT,   8'h45, 11'd0,    1, 1'b1, 8'h45, 0, 24, 16'h0000);
        add_row(tcw_pkg::OP_READ,  8'h00, 11'd1919, 1, 1'b1, 8'h00, 0, 24, 16'h1245);
        add_row(tcw_pkg::OP_CLEAR, 8'hFF, 11'd2047, 1, 1'b1, 8'h00, 0, 0,  16'h0000);
        add_row(tcw_pkg::OP_READ,  8'h00, 11'd0,    1, 1'b1, 8'h00, 0, 0,  16'h1220);
        add_row(tcw_pkg::OP_READ,  8'h00, 11'd1999, 1, 1'b1, 8'h00, 0, 0,  16'h1220);
        add_row(tcw_pkg::OP_READ,  8'h00, 11'd2000, 1, 1'b1, 8'h00, 0, 0,  16'h0000);

        for (i = 0; i < script_rows.size(); i++)
        begin
            s = script_rows[i];
            for (k = 0; k < int'(s.reps); k++)
                send_item(s.op, s.ch, s.idx, s.typed, s.want);
        end

        // Random phases: attribute and idling pattern change between them
        burst_count = 0;
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    write_attribute(16'h0000);
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1:
                begin
                    write_attribute(16'hFFFF);
                    send_gap_pct = 57;
                    stall_pct    = 0;
                end
                2:
                begin
                    write_attribute(tcw_pkg::CELL_W'($urandom));
                    send_gap_pct = 0;
                    stall_pct    = 57;
                end
                3:
                begin
                    write_attribute(16'h8001);
                    send_gap_pct = 18;
                    stall_pct    = 18;
                end
                default:
                begin
                    write_attribute(tcw_pkg::CELL_W'($urandom));
                    send_gap_pct = 57;
                    stall_pct    = 57;
                end
            endcase
            i = 0;
            while (i < PHASE_ITEMS)
            begin
                random_burst(counted);
                i += counted;
                burst_count++;
            end
        end

        // Drain: nothing outstanding, then watch for stray results
        send_gap_pct = 0;
        wait_idle();
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d puts, %0d reads, %0d clears in %0d random bursts",
                 puts_done, reads_done, clears_done, burst_count);
        $display("%0d scrolls and %0d line-end wraps, %0d attribute settings, %0d mismatches",
                 scrolls_done, wraps_done, PHASE_COUNT + 1, error_count);
        if (error_count == 0)
            $display("PASS text_console_writer");
        else
            $display("FAIL text_console_writer");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_UNITS);
        $display("FAIL text_console_writer");
        $finish;
    end

endmodule
